>>> hw/rtl/xeu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xeu_pkg
// Shared types, constants and entity tables of the entity decoder.
// ----------------------------------------------------------------------------
package xeu_pkg;

  localparam int NUM_ENT  = 5;
  localparam int HELD_MAX = 4;
  localparam int Q_DEPTH  = 4;

  // Entity codes, in candidate mask bit order.
  localparam int ENT_AMP  = 0;
  localparam int ENT_QUOT = 1;
  localparam int ENT_APOS = 2;
  localparam int ENT_LT   = 3;
  localparam int ENT_GT   = 4;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [4:0] ALL_CAND = 5'h1F;

  // One decoded step: an optional ampersand, then up to four held bytes,
  // then an optional tail byte.
  typedef struct packed {
    logic            amp;
    logic [2:0]      cnt;
    logic [3:0][7:0] held;
    logic            tail_v;
    logic [7:0]      tail;
    logic            last;
  } cmd_t;

  // Length of an entity name after the ampersand, semicolon included.
  function automatic logic [2:0] ent_len(input int e);
    logic [2:0] r;
    unique case (e)
      ENT_AMP:  r = 3'd4;
      ENT_QUOT: r = 3'd5;
      ENT_APOS: r = 3'd5;
      ENT_LT:   r = 3'd3;
      default:  r = 3'd3;
    endcase
    return r;
  endfunction

  // Character the entity stands for.
  function automatic logic [7:0] ent_char(input int e);
    logic [7:0] r;
    unique case (e)
      ENT_AMP:  r = CH_AMP;
      ENT_QUOT: r = CH_QUOT;
      ENT_APOS: r = CH_APOS;
      ENT_LT:   r = CH_LT;
      default:  r = CH_GT;
    endcase
    return r;
  endfunction

  // Expected byte of an entity at a position after the ampersand.
  function automatic logic [7:0] ent_text(input int e, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'h00;
    unique case (e)
      ENT_AMP: begin
        unique case (pos)
          3'd0: r = "a";
          3'd1: r = "m";
          3'd2: r = "p";
          3'd3: r = ";";
          default: r = 8'h00;
        endcase
      end
      ENT_QUOT: begin
        unique case (pos)
          3'd0: r = "q";
          3'd1: r = "u";
          3'd2: r = "o";
          3'd3: r = "t";
          3'd4: r = ";";
          default: r = 8'h00;
        endcase
      end
      ENT_APOS: begin
        unique case (pos)
          3'd0: r = "a";
          3'd1: r = "p";
          3'd2: r = "o";
          3'd3: r = "s";
          3'd4: r = ";";
          default: r = 8'h00;
        endcase
      end
      ENT_LT: begin
        unique case (pos)
          3'd0: r = "l";
          3'd1: r = "t";
          3'd2: r = ";";
          default: r = 8'h00;
        endcase
      end
      default: begin
        unique case (pos)
          3'd0: r = "g";
          3'd1: r = "t";
          3'd2: r = ";";
          default: r = 8'h00;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/xeu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xeu_front
// Accepts input bytes, tracks the entity match and issues at most one command per step.
// ----------------------------------------------------------------------------
module xeu_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_last,
  output logic              cmd_valid,
  input  wire logic         cmd_ready,
  output xeu_pkg::cmd_t     cmd
);
  import xeu_pkg::*;

  logic            pending, pending_next;
  logic [2:0]      held_count, held_count_next;
  logic [3:0][7:0] held, held_next;
  logic [4:0]      cand, cand_next;

  logic [4:0]      newmask;
  logic            hit;
  logic [7:0]      hit_char;
  logic            fresh;
  logic            accept;

  assign in_ready = cmd_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    newmask  = '0;
    hit      = 1'b0;
    hit_char = CH_AMP;
    for (int e = 0; e < NUM_ENT; e++) begin
      if (cand[e] && held_count < ent_len(e) && ent_text(e, held_count) == in_byte) begin
        newmask[e] = 1'b1;
        if (held_count + 3'd1 == ent_len(e)) begin
          hit      = 1'b1;
          hit_char = ent_char(e);
        end
      end
    end
  end

  always_comb begin
    pending_next    = pending;
    held_count_next = held_count;
    held_next       = held;
    cand_next       = cand;
    fresh           = 1'b1;
    cmd             = '0;
    cmd.last        = in_last;

    if (pending) begin
      if (hit) begin
        cmd.tail_v      = 1'b1;
        cmd.tail        = hit_char;
        pending_next    = 1'b0;
        held_count_next = '0;
        cand_next       = '0;
        fresh           = 1'b0;
      end else if (newmask != '0 && held_count < 3'(HELD_MAX)) begin
        held_next[held_count[1:0]] = in_byte;
        held_count_next            = held_count + 3'd1;
        cand_next                  = newmask;
        fresh                      = 1'b0;
      end else begin
        // Broken match: the ampersand and the held bytes go out literally.
        cmd.amp         = 1'b1;
        cmd.cnt         = held_count;
        pending_next    = 1'b0;
        held_count_next = '0;
        cand_next       = '0;
      end
    end

    if (fresh) begin
      if (in_byte == CH_AMP) begin
        pending_next    = 1'b1;
        held_count_next = '0;
        cand_next       = ALL_CAND;
      end else begin
        cmd.tail_v = 1'b1;
        cmd.tail   = in_byte;
      end
    end

    // End of stream flushes whatever match is still open.
    if (in_last && pending_next) begin
      if (cmd.amp) begin
        cmd.tail_v = 1'b1;
        cmd.tail   = CH_AMP;
      end else begin
        cmd.amp = 1'b1;
        cmd.cnt = held_count_next;
      end
      pending_next    = 1'b0;
      held_count_next = '0;
      cand_next       = '0;
    end

    cmd.held  = held_next;
    cmd_valid = accept && (cmd.amp || cmd.tail_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 1'b0;
      held_count <= '0;
      cand       <= '0;
    end else if (accept) begin
      pending    <= pending_next;
      held_count <= held_count_next;
      cand       <= cand_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/xeu_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xeu_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module xeu_queue (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  xeu_pkg::cmd_t  push_cmd,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output xeu_pkg::cmd_t  pop_cmd
);
  import xeu_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  cmd_t          slots [Q_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          do_push, do_pop;

  assign push_ready = (count != (PW+1)'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/xeu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xeu_back
// Expands each command into output bytes, one per cycle while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module xeu_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_ready,
  input  xeu_pkg::cmd_t   cmd,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            stream_last
);
  import xeu_pkg::*;

  logic [2:0] step;
  logic [2:0] total;
  logic [2:0] held_idx;
  logic [7:0] cur_byte;
  logic       is_final;
  logic       load;

  always_comb begin
    total    = cmd.amp ? (cmd.cnt + 3'd1 + {2'b00, cmd.tail_v}) : 3'd1;
    is_final = (step == total - 3'd1);
    held_idx = step - 3'd1;
    if (cmd.amp && step == 3'd0) begin
      cur_byte = CH_AMP;
    end else if (cmd.amp && step <= cmd.cnt) begin
      cur_byte = cmd.held[held_idx[1:0]];
    end else begin
      cur_byte = cmd.tail;
    end
  end

  assign load      = cmd_valid && (!out_valid || out_ready);
  assign cmd_ready = load && is_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= is_final ? 3'd0 : step + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= cur_byte;
      run_last    <= is_final;
      stream_last <= is_final && cmd.last;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/xml_entity_unescape.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xml_entity_unescape
// Streaming decoder for the five predefined XML entities.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle while the command queue has room; the
//   back end emits one byte per cycle while the output is not stalled.
// The front classifies each accepted item into the queue at the accepting edge,
// then the back end loads its output register from the queue.
// A step that flushes a broken match emits up to six bytes; the four-entry
// command queue absorbs such bursts.
// Reset (rst, synchronous): clears the match state, the queue and the output.
// ----------------------------------------------------------------------------
module xml_entity_unescape (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            stream_last
);
  import xeu_pkg::*;

  // The front end tracks the open match and turns each accepted item into a
  // command: an optional literal ampersand, the held bytes, and an optional tail byte.
  // Steps that only hold bytes produce no command.
  cmd_t f_cmd, b_cmd;
  logic f_valid, f_ready;
  logic b_valid, b_ready;

  xeu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // The queue lets the front keep accepting while the back expands a
  // long flush.
  xeu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd)
  );

  // The back end walks each command a byte at a time and marks the final
  // byte of the step, and of the stream when the step carried the last item.
  xeu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (b_valid),
    .cmd_ready   (b_ready),
    .cmd         (b_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .stream_last (stream_last)
  );

endmodule
`default_nettype wire

>>> verif/xml_entity_unescape_chk.sv
// ----------------------------------------------------------------------------
// xml_entity_unescape_chk
// Watches both channels of the entity decoder, keeps its own decoder state,
// and compares every output item with the byte and end marks it should carry.
// ----------------------------------------------------------------------------
module xml_entity_unescape_chk (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] out_byte,
  input  wire logic       run_last,
  input  wire logic       stream_last,
  output int              fail_count,
  output int              expected_left
);
  import xeu_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_last;
  } decoded_t;

  string      ent_name  [NUM_ENT];
  logic [7:0] ent_glyph [NUM_ENT];

  // Decoder state as the block should hold it.
  logic       amp_open;
  logic [2:0] held_cnt;
  logic [7:0] held [HELD_MAX];
  logic [4:0] cand_mask;

  decoded_t decoded_due [$];
  decoded_t step_out [$];

  initial begin
    ent_name[ENT_AMP]   = "amp;";
    ent_name[ENT_QUOT]  = "quot;";
    ent_name[ENT_APOS]  = "apos;";
    ent_name[ENT_LT]    = "lt;";
    ent_name[ENT_GT]    = "gt;";
    ent_glyph[ENT_AMP]  = CH_AMP;
    ent_glyph[ENT_QUOT] = CH_QUOT;
    ent_glyph[ENT_APOS] = CH_APOS;
    ent_glyph[ENT_LT]   = CH_LT;
    ent_glyph[ENT_GT]   = CH_GT;
    fail_count    = 0;
    expected_left = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] decoder mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic emit(input logic [7:0] b);
    decoded_t d;
    d.data        = b;
    d.run_last    = 1'b0;
    d.stream_last = 1'b0;
    step_out.push_back(d);
  endtask

  task automatic clear_match();
    amp_open  = 1'b0;
    held_cnt  = '0;
    cand_mask = '0;
  endtask

  // A broken or unfinished match goes out literally: the ampersand, then
  // the bytes held behind it.
  task automatic flush_match();
    emit(CH_AMP);
    for (int k = 0; k < held_cnt; k++) emit(held[k]);
    clear_match();
  endtask

  task automatic predict_item(input logic [7:0] b, input logic last);
    decoded_t   d;
    logic       fresh;
    logic [4:0] next_cand;
    int         hit;
    int         pos;
    step_out.delete();
    fresh = 1'b1;
    if (amp_open) begin
      pos       = held_cnt;
      next_cand = '0;
      hit       = -1;
      for (int e = 0; e < NUM_ENT; e++) begin
        if (cand_mask[e] && pos < ent_name[e].len() && ent_name[e][pos] == b) begin
          next_cand[e] = 1'b1;
          if (pos + 1 == ent_name[e].len()) hit = e;
        end
      end
      if (hit >= 0) begin
        emit(ent_glyph[hit]);
        clear_match();
        fresh = 1'b0;
      end else if (next_cand != '0 && pos < HELD_MAX) begin
        held[pos] = b;
        held_cnt  = 3'(pos + 1);
        cand_mask = next_cand;
        fresh     = 1'b0;
      end else begin
        flush_match();
      end
    end
    if (fresh) begin
      if (b == CH_AMP) begin
        amp_open  = 1'b1;
        held_cnt  = '0;
        cand_mask = ALL_CAND;
      end else begin
        emit(b);
      end
    end
    if (last && amp_open) flush_match();
    if (step_out.size() > 0) begin
      d = step_out.pop_back();
      d.run_last    = 1'b1;
      d.stream_last = last;
      step_out.push_back(d);
    end
    foreach (step_out[k]) decoded_due.push_back(step_out[k]);
  endtask

  always @(posedge clk) begin : watch
    decoded_t want;
    if (rst) begin
      clear_match();
      decoded_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_due.size() == 0) begin
          report_mismatch($sformatf("output item %02h with nothing expected", out_byte));
        end else begin
          want = decoded_due.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
          if (run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, want %b on byte %02h",
                                      run_last, want.run_last, want.data));
          if (stream_last !== want.stream_last)
            report_mismatch($sformatf("stream_last %b, want %b on byte %02h",
                                      stream_last, want.stream_last, want.data));
        end
      end
      if (in_valid && in_ready) predict_item(in_byte, in_last);
    end
    expected_left = decoded_due.size();
  end

endmodule

>>> verif/xml_entity_unescape_tb.sv
// ----------------------------------------------------------------------------
// xml_entity_unescape_tb
// Drives text streams into the entity decoder with random gaps and output
// stalls; a checker beside the block predicts and compares every output item.
// ----------------------------------------------------------------------------
module xml_entity_unescape_tb;
  import xeu_pkg::*;

  // Roughly how many random input items follow the directed streams.
  localparam int RANDOM_ITEMS = 390;
  // Cycles to wait after the last expected byte, so that a stray extra
  // output item would still show up.
  localparam int DRAIN_CYCLES = 20;

  // All block inputs start at known values at time zero.
  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_ready = 1'b0;

  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_last;

  int fail_count;
  int expected_left;

  // When set, the sender puts no gaps between items of the current stream.
  logic in_calm  = 1'b0;
  // When set, the receiver starts no new stalls; it flips now and then.
  logic out_calm = 1'b0;
  int   stall_left;

  string names [NUM_ENT];

  always #2 clk = ~clk;

  xml_entity_unescape u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .stream_last (stream_last)
  );

  xml_entity_unescape_chk u_chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .run_last      (run_last),
    .stream_last   (stream_last),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  // Offers one item and returns at the edge where it is taken. A gap, if one
  // is drawn, drops valid first; otherwise valid stays high from the last
  // item and only the payload moves on, so valid sees a single assignment
  // per edge.
  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (in_calm || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sends a string; the final character carries the stream end mark when
  // asked.
  task automatic send_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) send_item(s[i], last && (i == s.len() - 1));
  endtask

  // The receiver: mostly ready, with short stalls and a few long ones.
  always @(posedge clk) begin : receiver
    int r;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if ($urandom_range(0, 299) == 0) out_calm <= ~out_calm;
      if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (!out_calm) begin
          if (r < 20) stall_left <= $urandom_range(1, 3);
          else if (r < 23) stall_left <= $urandom_range(10, 30);
        end
      end
    end
  end

  initial begin : stimulus
    logic [7:0] text [$];
    string      alpha;
    int         sent;
    int         len;
    int         r;
    int         e;
    int         cut;
    names[ENT_AMP]  = "amp;";
    names[ENT_QUOT] = "quot;";
    names[ENT_APOS] = "apos;";
    names[ENT_LT]   = "lt;";
    names[ENT_GT]   = "gt;";
    // Letters that keep a match alive for a while before it breaks.
    alpha = "amposqutlg;";
    sent  = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every entity in turn, back to back.
    send_text("&amp;&quot;&apos;&lt;&gt;", 1'b0);
    // A match that dies at the last held byte: the ampersand, four held
    // bytes and the breaking byte all come out of a single item.
    send_text("&apos", 1'b0);
    send_item(8'hFF, 1'b0);
    // A name without its semicolon is not decoded, and a zero byte passes.
    send_text("&gt", 1'b0);
    send_item(8'h00, 1'b0);
    // A second ampersand breaks the match and opens a new one, which the
    // stream end then flushes as well.
    send_text("&quo&", 1'b1);

    // Random streams. Most of the content is whole or nearly whole entities,
    // so matches get deep; the rest is bare ampersands, entity letters and
    // arbitrary bytes.
    while (sent < RANDOM_ITEMS) begin
      in_calm = ($urandom_range(0, 5) == 0);
      len = $urandom_range(1, 24);
      text.delete();
      while (text.size() < len) begin
        r = $urandom_range(0, 99);
        e = $urandom_range(0, NUM_ENT - 1);
        if (r < 40) begin
          text.push_back(CH_AMP);
          for (int i = 0; i < names[e].len(); i++) text.push_back(names[e][i]);
        end else if (r < 55) begin
          // A prefix of a name broken by some byte, which may itself be an
          // ampersand or even the right next letter.
          cut = $urandom_range(0, names[e].len() - 1);
          text.push_back(CH_AMP);
          for (int i = 0; i < cut; i++) text.push_back(names[e][i]);
          text.push_back(8'($urandom_range(0, 255)));
        end else if (r < 63) begin
          text.push_back(CH_AMP);
        end else if (r < 80) begin
          text.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
        end else begin
          text.push_back(8'($urandom_range(0, 255)));
        end
      end
      foreach (text[i]) send_item(text[i], i == text.size() - 1);
      sent += text.size();
    end
    in_valid <= 1'b0;

    // Sampled away from the rising edge so that the checker's count is
    // settled, including the prediction for the final item.
    @(negedge clk);
    while (expected_left != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_left == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // The slowest correct run is well under a tenth of this.
  initial begin : watchdog
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
